/* design/mfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 3;

  localparam int ID_W    = 4;
  localparam int LEN_W   = 16;
  localparam int BQ_W    = 8;
  localparam int SLICE_W = 10;
  localparam int TIME_W  = 32;
  localparam int OLVL_W  = 2;
  localparam int SDATA_W = 24;
  localparam int MDATA_W = 48;
  localparam int SUSER_W = 1;
  localparam int MUSER_W = 2;

  localparam logic [BQ_W-1:0]    BQ_RESET  = 8'd2;
  localparam logic [SLICE_W-1:0] SLICE_MAX = 10'd1023;

  typedef enum logic [1:0] {
    ST_READY,
    ST_RUNNING,
    ST_TERMINATED
  } task_status_t;

  typedef struct packed {
    task_status_t       status;
    logic [LEN_W-1:0]   need;
    logic [LEN_W-1:0]   done;
    logic [SLICE_W-1:0] slice;
  } task_rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADMIT,
    S_LOOK,
    S_READ,
    S_DECIDE,
    S_LOOK2,
    S_READ2,
    S_ELECT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic admit;
    logic look;
    logic rd_task;
    logic decide;
    logic elect;
    logic emit;
  } mfq_cmd_t;

  typedef struct packed {
    logic empty;
    logic resolve;
    logic out_free;
  } mfq_stat_t;

endpackage

/* design/mfq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfq_ctrl
// Sequencer: steps an admit into the queues and a tick through lookup, decision and election.
// ----------------------------------------------------------------------------
module mfq_ctrl
  import mfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tuser,
  output logic      s_tready,
  input  mfq_stat_t stat,
  output mfq_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = s_tuser ? S_LOOK : S_ADMIT;
        end
      end
      S_ADMIT: begin
        cmd.admit  = 1'b1;
        state_next = S_IDLE;
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = stat.empty ? S_OUT : S_READ;
      end
      S_READ: begin
        cmd.rd_task = 1'b1;
        state_next  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.resolve ? S_LOOK2 : S_OUT;
      end
      S_LOOK2: begin
        cmd.look   = 1'b1;
        state_next = stat.empty ? S_OUT : S_READ2;
      end
      S_READ2: begin
        cmd.rd_task = 1'b1;
        state_next  = S_ELECT;
      end
      S_ELECT: begin
        cmd.elect  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/mfq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfq_dp
// Datapath: level FIFOs in one memory, task table memory, counters, output.
// ----------------------------------------------------------------------------
module mfq_dp
  import mfq_pkg::*;
#(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SDATA_W-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,
  output logic [MUSER_W-1:0] m_tuser,
  input  logic               cfg_wr_en,
  input  logic [BQ_W-1:0]    cfg_wr_data,
  input  mfq_cmd_t           cmd,
  output mfq_stat_t          stat
);

  localparam int PTR_W  = $clog2(MAX_TASKS);
  localparam int FILL_W = $clog2(MAX_TASKS + 1);
  localparam int TIDX_W = $clog2(MAX_TASKS);
  localparam int LI_W   = $clog2(NUM_LEVELS);
  localparam int FD     = NUM_LEVELS * MAX_TASKS;
  localparam int AW     = $clog2(FD);
  localparam int LIM_W  = LI_W + BQ_W + 1;

  function automatic logic [AW-1:0] faddr(logic [LI_W-1:0] l, logic [PTR_W-1:0] p);
    return AW'(l) * AW'(MAX_TASKS) + AW'(p);
  endfunction

  function automatic logic [PTR_W-1:0] pinc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic task_rec_t charged(task_rec_t r);
    task_rec_t c;
    c        = r;
    c.status = ST_RUNNING;
    c.done   = r.done + 1'b1;
    if (r.slice < SLICE_MAX) begin
      c.slice = r.slice + 1'b1;
    end
    return c;
  endfunction

  logic [BQ_W-1:0]   bq;
  logic [ID_W-1:0]   in_id;
  logic [LEN_W-1:0]  in_len;
  logic [PTR_W-1:0]  head [NUM_LEVELS];
  logic [PTR_W-1:0]  tail [NUM_LEVELS];
  logic [FILL_W-1:0] fill [NUM_LEVELS];
  logic [LI_W-1:0]   cur_lvl;
  logic [ID_W-1:0]   fifo_q;
  task_rec_t         rec_q;
  logic              res_ev;
  logic [ID_W-1:0]   res_id;
  logic [OLVL_W-1:0] res_lvl;
  logic              fin_v;
  logic [ID_W-1:0]   fin_id;
  logic [TIME_W-1:0] tick;

  logic [ID_W-1:0] fifo_mem [FD];
  task_rec_t       task_mem [MAX_TASKS];

  // head lookup over the level fill counts
  logic [LI_W-1:0] top_lvl;
  logic            empty;
  always_comb begin
    top_lvl = '0;
    empty   = 1'b1;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (fill[l] != '0) begin
        top_lvl = LI_W'(l);
        empty   = 1'b0;
      end
    end
  end

  // decision on the head record
  logic [LI_W-1:0]  tgt;
  logic [LIM_W-1:0] limit;
  logic             running, fin, dem, tgt_full, admit_ok;
  always_comb begin
    tgt      = (cur_lvl == LI_W'(NUM_LEVELS - 1)) ? '0 : cur_lvl + 1'b1;
    limit    = (LIM_W'(cur_lvl) + 1'b1) * LIM_W'(bq);
    running  = rec_q.status == ST_RUNNING;
    fin      = running && (rec_q.done >= rec_q.need);
    dem      = running && !fin && (LIM_W'(rec_q.slice) >= limit);
    tgt_full = fill[tgt] == FILL_W'(MAX_TASKS);
    admit_ok = (int'(in_id) < MAX_TASKS) && (fill[0] != FILL_W'(MAX_TASKS));
  end

  assign stat.empty    = empty;
  assign stat.resolve  = fin || dem;
  assign stat.out_free = !m_tvalid || m_tready;

  // task table write port
  logic              t_we;
  logic [TIDX_W-1:0] t_idx;
  task_rec_t         t_wd;
  always_comb begin
    t_we  = 1'b0;
    t_idx = TIDX_W'(fifo_q);
    t_wd  = charged(rec_q);
    if (cmd.admit) begin
      t_we  = admit_ok;
      t_idx = TIDX_W'(in_id);
      t_wd  = '{status: ST_READY, need: in_len, done: '0, slice: '0};
    end else if (cmd.decide) begin
      t_we = 1'b1;
      if (fin) begin
        t_wd        = rec_q;
        t_wd.status = ST_TERMINATED;
      end else if (dem) begin
        t_wd        = rec_q;
        t_wd.status = ST_READY;
        t_wd.slice  = '0;
      end
    end else if (cmd.elect) begin
      t_we = 1'b1;
    end
  end

  // FIFO write port and push/pop
  logic            f_we;
  logic [AW-1:0]   f_addr;
  logic [ID_W-1:0] f_wd;
  logic            push_any, pop_any;
  logic [LI_W-1:0] push_lvl;
  always_comb begin
    f_we     = 1'b0;
    f_addr   = faddr(tgt, tail[tgt]);
    f_wd     = fifo_q;
    push_lvl = tgt;
    pop_any  = cmd.decide && (fin || dem);
    if (cmd.admit) begin
      f_we     = admit_ok;
      push_lvl = '0;
      f_addr   = faddr('0, tail[0]);
      f_wd     = in_id;
    end else if (cmd.decide && dem && !tgt_full) begin
      f_we = 1'b1;
    end
    push_any = f_we;
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fifo_mem[f_addr] <= f_wd;
    end
    if (cmd.look) begin
      fifo_q <= fifo_mem[faddr(top_lvl, head[top_lvl])];
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      task_mem[t_idx] <= t_wd;
    end
    if (cmd.rd_task) begin
      rec_q <= task_mem[TIDX_W'(fifo_q)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
        fill[l] <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (push_any && push_lvl == LI_W'(l)) begin
          tail[l] <= pinc(tail[l]);
          fill[l] <= fill[l] + 1'b1;
        end
        if (pop_any && cur_lvl == LI_W'(l)) begin
          head[l] <= pinc(head[l]);
          fill[l] <= fill[l] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bq <= BQ_RESET;
    end else if (cfg_wr_en) begin
      bq <= cfg_wr_data;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_id  <= s_tdata[ID_W-1:0];
      in_len <= s_tdata[ID_W +: LEN_W];
      fin_v  <= 1'b0;
      fin_id <= '0;
    end
    if (cmd.look) begin
      cur_lvl <= top_lvl;
      if (empty) begin
        res_ev  <= 1'b0;
        res_id  <= '0;
        res_lvl <= '0;
      end
    end
    if (cmd.decide && fin) begin
      fin_v  <= 1'b1;
      fin_id <= fifo_q;
    end
    if (cmd.elect || (cmd.decide && !fin && !dem)) begin
      res_ev  <= 1'b1;
      res_id  <= fifo_q;
      res_lvl <= OLVL_W'(cur_lvl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      tick     <= '0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
      tick     <= tick + 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // finish time is the tick count only on a termination, zero otherwise
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {(MDATA_W - TIME_W - 2 * ID_W - OLVL_W)'(0), (fin_v ? tick : '0),
                  fin_id, res_lvl, res_id};
      m_tuser <= {fin_v, res_ev};
    end
  end

endmodule

/* design/multilevel_feedback_queue_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Feedback-queue task scheduler with NUM_LEVELS circular priority FIFOs.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  s_*      | in        | tuser: req_type; tdata: admit_task, admit_length
//  m_*      | out       | tuser: elected_valid, finished_valid;
//           |           | tdata: elected_task, elected_level, finished_task,
//           |           |        finish_time
//  cfg_*    | in        | base_quantum write
//
//  An admit is written in its admit step. A tick looks up the top level; when
//  the queues are empty it goes straight to output, else the head record is
//  read and a decision made. A head that terminates or is demoted leads to a
//  second lookup, read and election, or to output if the queues are then empty;
//  FIFO and task table reads are registered. Reset is synchronous; no clearing
//  pass is needed. A stalled output holds the sequencer in its output step;
//  input is taken only while idle.
module multilevel_feedback_queue_scheduler
  import mfq_pkg::*;
#(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [SDATA_W-1:0] s_tdata,   // admit_task, admit_length
  input  logic [SUSER_W-1:0] s_tuser,   // req_type
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,   // elected_task, elected_level,
                                        // finished_task, finish_time
  output logic [MUSER_W-1:0] m_tuser,   // elected_valid, finished_valid
  input  logic               cfg_wr_en,
  input  logic [BQ_W-1:0]    cfg_wr_data
);

  mfq_cmd_t  cmd;
  mfq_stat_t stat;

  mfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser[0]),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfq_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.emit))
    else $error("output valid without a result");
`endif

endmodule

/* dv/multilevel_feedback_queue_scheduler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_tb
// Self-checking bench for the feedback-queue scheduler. Admit and tick
// requests go in over the input stream. A local scheduler model predicts
// every tick result, and each output transfer is compared field by field.
// The run passes through several quantum settings and ready/valid idle mixes.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_tb;
  import mfq_pkg::*;

  localparam bit REQ_ADMIT = 1'b0;
  localparam bit REQ_TICK  = 1'b1;
  localparam int WDOG_MAX  = 5000;
  localparam int SETTLE    = 12;

  typedef struct {
    bit          tick;
    logic [3:0]  task_id;
    logic [15:0] length;
  } sched_req_t;

  typedef struct packed {
    logic        ev;
    logic [3:0]  et;
    logic [1:0]  el;
    logic        fv;
    logic [3:0]  ft;
    logic [31:0] fti;
  } sched_res_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [SDATA_W-1:0] s_tdata;
  logic [SUSER_W-1:0] s_tuser;
  logic [MDATA_W-1:0] m_tdata;
  logic [MUSER_W-1:0] m_tuser;
  logic cfg_wr_en;
  logic [BQ_W-1:0] cfg_wr_data;

  multilevel_feedback_queue_scheduler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // scheduler model state
  logic [3:0]   run_q[NUM_LEVELS_DEF][$];
  task_status_t tsk_status[MAX_TASKS_DEF];
  logic [15:0]  tsk_need[MAX_TASKS_DEF];
  logic [15:0]  tsk_done[MAX_TASKS_DEF];
  logic [9:0]   tsk_slice[MAX_TASKS_DEF];
  logic [31:0]  tick_cnt;
  logic [7:0]   quantum;

  sched_req_t pend_reqs[$];
  sched_res_t expected_res[$];
  int send_idle, recv_idle;
  bit in_xfer;
  int mismatches, wdog;
  int n_ticks, n_admits, n_fin, n_idle;

  function automatic int top_level();
    int l;
    for (l = 0; l < NUM_LEVELS_DEF; l++)
      if (run_q[l].size() != 0) return l;
    return NUM_LEVELS_DEF;
  endfunction

  function automatic void charge_task(int id);
    tsk_done[id] = tsk_done[id] + 16'd1;
    if (tsk_slice[id] < SLICE_MAX) tsk_slice[id] = tsk_slice[id] + 10'd1;
  endfunction

  task automatic schedule_step(input sched_req_t rq, output bit has, output sched_res_t r);
    int l, id, nl;
    bit keep;
    r = '0;
    has = 0;
    keep = 0;
    if (!rq.tick) begin
      // admit is dropped when level 0 is full
      if (run_q[0].size() >= MAX_TASKS_DEF) return;
      id = rq.task_id;
      tsk_status[id] = ST_READY;
      tsk_need[id] = rq.length;
      tsk_done[id] = '0;
      tsk_slice[id] = '0;
      run_q[0].push_back(rq.task_id);
      return;
    end
    has = 1;
    l = top_level();
    if (l < NUM_LEVELS_DEF) begin
      id = run_q[l][0];
      if (tsk_status[id] == ST_RUNNING) begin
        if (tsk_done[id] >= tsk_need[id]) begin
          tsk_status[id] = ST_TERMINATED;
          r.fv = 1;
          r.ft = 4'(id);
          r.fti = tick_cnt;
          void'(run_q[l].pop_front());
        end else if (int'(tsk_slice[id]) >= (l + 1) * int'(quantum)) begin
          tsk_status[id] = ST_READY;
          tsk_slice[id] = '0;
          void'(run_q[l].pop_front());
          nl = (l + 1) % NUM_LEVELS_DEF;
          // demotion into a full level drops the task
          if (run_q[nl].size() < MAX_TASKS_DEF) run_q[nl].push_back(4'(id));
        end else begin
          charge_task(id);
          keep = 1;
        end
      end
      if (!keep) begin
        l = top_level();
        if (l < NUM_LEVELS_DEF) begin
          id = run_q[l][0];
          charge_task(id);
          tsk_status[id] = ST_RUNNING;
        end
      end
    end
    if (l < NUM_LEVELS_DEF) begin
      r.ev = 1;
      r.et = run_q[l][0];
      r.el = 2'(l);
    end
    tick_cnt = tick_cnt + 32'd1;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    sched_req_t it;
    m_tready <= ($urandom_range(99) >= recv_idle);
    if (!s_tvalid || in_xfer) begin
      if (pend_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        it = pend_reqs.pop_front();
        s_tdata <= {4'd0, it.length, it.task_id};
        s_tuser <= it.tick;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    sched_res_t got, exp_r;
    sched_req_t rq;
    bit has;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        got.ev = m_tuser[0];
        got.fv = m_tuser[1];
        got.et = m_tdata[3:0];
        got.el = m_tdata[5:4];
        got.ft = m_tdata[9:6];
        got.fti = m_tdata[41:10];
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_res.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        rq.tick = s_tuser[0];
        rq.task_id = s_tdata[3:0];
        rq.length = s_tdata[19:4];
        schedule_step(rq, has, exp_r);
        if (rq.tick) begin
          n_ticks++;
          if (!exp_r.ev) n_idle++;
          if (exp_r.fv) n_fin++;
        end else begin
          n_admits++;
        end
        if (has) expected_res.push_back(exp_r);
      end
      if (moved) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
        $display("multilevel_feedback_queue_scheduler_tb: errors");
        $finish;
      end
    end
    in_xfer <= !rst && s_tvalid && s_tready;
  end

  function automatic sched_req_t mk_req(bit tick, int id, int len);
    sched_req_t q;
    q.tick = tick;
    q.task_id = 4'(id);
    q.length = 16'(len);
    return q;
  endfunction

  function automatic sched_req_t rand_req();
    int p, len;
    p = $urandom_range(99);
    if (p < 5) len = $urandom_range(65535);
    else if (p < 7) len = 0;
    else len = $urandom_range(1, 12);
    return mk_req($urandom_range(99) >= 30, $urandom_range(15), len);
  endfunction

  task automatic wait_idle();
    while (pend_reqs.size() > 0 || s_tvalid || expected_res.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_quantum(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    quantum = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int ph, i;
    int ph_q[6];
    int ph_mode[6];
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_xfer = 0;
    send_idle = 30;
    recv_idle = 65;
    mismatches = 0;
    wdog = 0;
    n_ticks = 0; n_admits = 0; n_fin = 0; n_idle = 0;
    foreach (run_q[l]) run_q[l].delete();
    tick_cnt = '0;
    quantum = BQ_RESET;
    rst = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    ph_q = '{1, 255, 0, $urandom_range(3, 254), 2, $urandom_range(1, 254)};
    ph_mode = '{0, 0, 1, 1, 2, 2};
    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      set_quantum(8'(ph_q[ph]));
      send_idle = (ph_mode[ph] == 0) ? 30 : (ph_mode[ph] == 1) ? 65 : 0;
      recv_idle = (ph_mode[ph] == 0) ? 65 : (ph_mode[ph] == 1) ? 30 : 0;
      if (ph == 0) begin
        // empty-queue tick, extreme ids and lengths, then overfill level 0
        pend_reqs.push_back(mk_req(REQ_TICK, 0, 0));
        pend_reqs.push_back(mk_req(REQ_ADMIT, 0, 0));
        pend_reqs.push_back(mk_req(REQ_ADMIT, 15, 65535));
        for (i = 1; i <= 15; i++) pend_reqs.push_back(mk_req(REQ_ADMIT, i, 3));
        for (i = 0; i < 5; i++) pend_reqs.push_back(mk_req(REQ_TICK, 0, 0));
      end else begin
        for (i = 0; i < 320; i++) pend_reqs.push_back(rand_req());
      end
    end

    wait_idle();
    $display("covered %0d admits and %0d ticks (%0d idle), %0d terminations",
             n_admits, n_ticks, n_idle, n_fin);
    $display("quantum settings 1, 255, 0, 2 and two random; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("multilevel_feedback_queue_scheduler_tb: clean");
    end else begin
      $display("multilevel_feedback_queue_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
